### rtl/http_request_header_scanner_unit_assert.svh
// assertion macros used by the header scanner core
`ifndef HTTP_REQUEST_HEADER_SCANNER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEADER_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HRHS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrhs: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HRHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrhs: next-cycle check failed");

`endif

### rtl/hrhs_pkg.sv
// types, constants and per-byte scan functions of the http request header scanner
`default_nettype none

package hrhs_pkg;

    localparam int QUERY_OFF_W = 12;
    localparam int QUERY_LEN_W = 13;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // words right-justified, first character in the highest used byte
    localparam logic [79:0] WORD_GET        = 80'("GET");
    localparam logic [79:0] WORD_HTTP10     = 80'("HTTP/1.0");
    localparam logic [79:0] WORD_CONNECTION = 80'("Connection");
    localparam logic [79:0] WORD_CLOSE      = 80'("close");
    localparam logic [79:0] WORD_KEEP_ALIVE = 80'("keep-alive");

    // candidate slots within a token
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_NAME   = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_METHOD = 2'd1;
    localparam logic [1:0] STATUS_BAD_LINE   = 2'd2;

    localparam logic [1:0] VER_NONE  = 2'd0;
    localparam logic [1:0] VER_1_0   = 2'd1;
    localparam logic [1:0] VER_NEWER = 2'd2;

    localparam logic [2:0] TOK_LIMIT = 3'd4;
    localparam logic [3:0] POS_LIMIT = 4'd15;

    typedef enum logic [1:0] {
        OC_GO_ON,
        OC_END_OK,
        OC_BAD_METHOD,
        OC_BAD_LINE
    } outcome_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   method_is_get;
        logic [1:0]             http_version;
        logic                   keep_alive;
        logic                   query_present;
        logic [QUERY_OFF_W-1:0] query_offset;
        logic [QUERY_LEN_W-1:0] query_length;
    } out_t;

    typedef struct packed {
        logic                   line_nz;
        logic [2:0]             tok_cnt;
        logic                   tok_empty;
        logic                   pend_cr;
        logic [3:0]             match_pos;
        logic [2:0]             match_flags;
        logic                   value_skip;
        logic                   name_known;
        logic                   name_is_conn;
        logic [1:0]             version;
        logic                   method_seen;
        logic                   conn_seen;
        logic                   keep_alive;
        logic [QUERY_LEN_W-1:0] q_start;
        logic [QUERY_LEN_W-1:0] q_size;
        logic                   q_found;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        outcome_t    oc;
    } scan_step_t;

    function automatic scan_state_t new_segment(scan_state_t s);
        scan_state_t r;
        r = s;
        r.tok_empty   = 1'b1;
        r.match_pos   = '0;
        r.match_flags = '1;
        r.value_skip  = 1'b1;
        return r;
    endfunction

    function automatic scan_state_t reset_state();
        scan_state_t r;
        r = '0;
        r.tok_cnt    = 3'd1;
        r.keep_alive = 1'b1;
        r.version    = VER_NONE;
        return new_segment(r);
    endfunction

    function automatic logic [79:0] word_text(logic t, logic [1:0] k);
        logic [79:0] w;
        case (k)
            SLOT_FIRST:  w = t ? WORD_CLOSE : WORD_GET;
            SLOT_SECOND: w = t ? WORD_KEEP_ALIVE : WORD_HTTP10;
            default:     w = WORD_CONNECTION;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] word_len(logic t, logic [1:0] k);
        logic [3:0] n;
        case (k)
            SLOT_FIRST:  n = t ? 4'd5 : 4'd3;
            SLOT_SECOND: n = t ? 4'd10 : 4'd8;
            default:     n = 4'd10;
        endcase
        return n;
    endfunction

    // header values are matched without regard to case, the header name is not
    function automatic logic word_nocase(logic t, logic [1:0] k);
        return t && (k != SLOT_NAME);
    endfunction

    // the version token only has to start with its word
    function automatic logic word_prefix(logic t, logic [1:0] k);
        return !t && (k == SLOT_SECOND);
    endfunction

    function automatic logic [7:0] word_char(logic t, logic [1:0] k, logic [3:0] i);
        logic [79:0] w;
        logic [3:0]  sel;
        logic [6:0]  idx;
        w   = word_text(t, k);
        sel = word_len(t, k) - 4'd1 - i;
        idx = {sel, 3'b000};
        return w[idx +: 8];
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_DELTA : c;
    endfunction

    function automatic logic matched(scan_state_t s, logic [1:0] k);
        logic [3:0] len;
        len = word_len(s.line_nz, k);
        if (!s.match_flags[k]) begin
            return 1'b0;
        end
        return word_prefix(s.line_nz, k) ? (s.match_pos >= len) : (s.match_pos == len);
    endfunction

    function automatic scan_state_t feed(scan_state_t s, logic [7:0] b);
        scan_state_t r;
        logic [3:0]  len;
        logic [7:0]  c;
        r = s;
        r.tok_empty = 1'b0;
        if (s.line_nz && s.value_skip && b == CHAR_SPACE) begin
            r.match_flags[SLOT_NAME] = 1'b0;
            return r;
        end
        r.value_skip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            len = word_len(s.line_nz, k[1:0]);
            if (s.match_pos < len) begin
                c = word_nocase(s.line_nz, k[1:0]) ? fold(b) : b;
                if (c != word_char(s.line_nz, k[1:0], s.match_pos)) begin
                    r.match_flags[k[1:0]] = 1'b0;
                end
            end else if (!word_prefix(s.line_nz, k[1:0])) begin
                r.match_flags[k[1:0]] = 1'b0;
            end
        end
        if (s.match_pos < POS_LIMIT) begin
            r.match_pos = s.match_pos + 4'd1;
        end
        return r;
    endfunction

    function automatic scan_step_t ordinary(scan_state_t s, logic [7:0] b,
                                            logic [QUERY_LEN_W-1:0] p);
        scan_step_t r;
        r.st = s;
        r.oc = OC_GO_ON;
        if (!s.line_nz && b == CHAR_SPACE) begin
            if (!s.tok_empty) begin
                if (s.tok_cnt == 3'd1) begin
                    if (!matched(s, SLOT_FIRST)) begin
                        r.oc = OC_BAD_METHOD;
                        return r;
                    end
                    r.st.method_seen = 1'b1;
                end else if (s.tok_cnt == 3'd2 && !s.q_found) begin
                    r.st.q_found = 1'b1;
                    r.st.q_size  = p - s.q_start;
                end
                if (s.tok_cnt < TOK_LIMIT) begin
                    r.st.tok_cnt = s.tok_cnt + 3'd1;
                end
            end
            if (!r.st.q_found) begin
                r.st.q_start = p + 1'b1;
            end
            r.st = new_segment(r.st);
        end else if (b == CHAR_COLON && s.tok_cnt == 3'd1) begin
            r.st.name_known   = 1'b1;
            r.st.name_is_conn = matched(s, SLOT_NAME);
            if (!s.line_nz && !s.q_found) begin
                r.st.q_start = p + 1'b1;
            end
            r.st.tok_cnt = 3'd0;
            r.st = new_segment(r.st);
        end else begin
            r.st = feed(s, b);
        end
        return r;
    endfunction

    function automatic scan_step_t take_byte(scan_state_t s, logic [7:0] b,
                                             logic [QUERY_LEN_W-1:0] p);
        scan_step_t r;
        if (b == CHAR_CR) begin
            r.st = s;
            r.st.pend_cr = 1'b1;
            r.oc = OC_GO_ON;
        end else begin
            r = ordinary(s, b, p);
        end
        return r;
    endfunction

    function automatic scan_step_t line_end(scan_state_t s);
        scan_step_t r;
        r.st = s;
        r.oc = OC_GO_ON;
        if (s.tok_empty && s.line_nz) begin
            r.oc = OC_END_OK;
            return r;
        end
        if (!s.line_nz) begin
            if (s.tok_cnt != 3'd3) begin
                r.oc = OC_BAD_LINE;
                return r;
            end
            r.st.version = matched(s, SLOT_SECOND) ? VER_1_0 : VER_NEWER;
        end else if (s.name_known && s.name_is_conn) begin
            if (matched(s, SLOT_FIRST)) begin
                r.st.keep_alive = 1'b0;
            end else if (matched(s, SLOT_SECOND)) begin
                r.st.keep_alive = 1'b1;
            end else begin
                r.st.keep_alive = (s.version == VER_NEWER);
            end
            r.st.conn_seen = 1'b1;
        end
        r.st.line_nz = 1'b1;
        r.st.tok_cnt = 3'd1;
        r.st = new_segment(r.st);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/hrhs_in_stage.sv
// input register stage holding one header byte for the scan logic
`default_nettype none

module hrhs_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire hrhs_pkg::in_t s_data,
    input  wire logic          take,
    output logic               byte_valid,
    output hrhs_pkg::in_t      byte_data
);

    logic          valid_reg;
    logic          valid_next;
    hrhs_pkg::in_t data_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

### rtl/hrhs_scan_core.sv
// per-byte scan state and the logic that advances it and forms the result
`default_nettype none

`include "http_request_header_scanner_unit_assert.svh"

module hrhs_scan_core #(
    parameter int MAX_HEADER_BYTES = 4096
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_valid,
    input  wire hrhs_pkg::in_t byte_data,
    input  wire logic          res_room,
    output logic               take,
    output logic               res_valid,
    output hrhs_pkg::out_t     res_data
);

    localparam int POS_W = $clog2(MAX_HEADER_BYTES);
    localparam int QL_W  = hrhs_pkg::QUERY_LEN_W;
    localparam int PX_W  = (POS_W > QL_W) ? POS_W : QL_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_HEADER_BYTES - 1);

    hrhs_pkg::scan_state_t state_reg;
    hrhs_pkg::scan_state_t state_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  result_given_reg;
    logic                  result_given_next;

    hrhs_pkg::scan_step_t  step;
    logic [7:0]            b;
    logic                  last_w;
    logic                  ka_final;
    logic [PX_W-1:0]       pos_ext;
    logic [QL_W-1:0]       p13;

    assign take    = byte_valid && res_room;
    assign b       = byte_data.data_byte;
    assign last_w  = byte_data.end_of_packet || (pos_reg == LAST_POS);
    assign pos_ext = PX_W'(pos_reg);
    assign p13     = pos_ext[QL_W-1:0];

    always_comb begin
        step.st = state_reg;
        step.oc = hrhs_pkg::OC_GO_ON;
        if (b == hrhs_pkg::CHAR_NUL) begin
            step.oc = hrhs_pkg::OC_END_OK;
        end else if (state_reg.pend_cr) begin
            step.st.pend_cr = 1'b0;
            if (b == hrhs_pkg::CHAR_LF) begin
                step = hrhs_pkg::line_end(step.st);
            end else begin
                // lone cr is an ordinary byte ahead of this one
                step = hrhs_pkg::ordinary(step.st, hrhs_pkg::CHAR_CR, p13);
                if (step.oc == hrhs_pkg::OC_GO_ON) begin
                    step = hrhs_pkg::take_byte(step.st, b, p13);
                end
            end
        end else begin
            step = hrhs_pkg::take_byte(state_reg, b, p13);
        end
        if (step.oc == hrhs_pkg::OC_GO_ON && last_w) begin
            step.oc = hrhs_pkg::OC_END_OK;
        end
    end

    always_comb begin
        ka_final = step.st.conn_seen ? step.st.keep_alive
                                     : (step.st.version == hrhs_pkg::VER_NEWER);
        res_data = '0;
        case (step.oc)
            hrhs_pkg::OC_END_OK: begin
                res_data.status       = hrhs_pkg::STATUS_OK;
                res_data.http_version = step.st.version;
                res_data.keep_alive   = ka_final;
            end
            hrhs_pkg::OC_BAD_METHOD: begin
                res_data.status = hrhs_pkg::STATUS_BAD_METHOD;
            end
            default: begin
                res_data.status = hrhs_pkg::STATUS_BAD_LINE;
            end
        endcase
        res_data.method_is_get = step.st.method_seen;
        res_data.query_present = step.st.q_found;
        if (step.st.q_found) begin
            res_data.query_offset = step.st.q_start[hrhs_pkg::QUERY_OFF_W-1:0];
            res_data.query_length = step.st.q_size;
        end
        res_valid = take && !result_given_reg && (step.oc != hrhs_pkg::OC_GO_ON);
    end

    always_comb begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        result_given_next = result_given_reg;
        if (take) begin
            if (result_given_reg) begin
                // drain to the end of the packet, then start over
                if (byte_data.end_of_packet) begin
                    state_next        = hrhs_pkg::reset_state();
                    pos_next          = '0;
                    result_given_next = 1'b0;
                end
            end else if (last_w) begin
                state_next        = hrhs_pkg::reset_state();
                pos_next          = '0;
                result_given_next = 1'b0;
            end else begin
                state_next        = step.st;
                pos_next          = pos_reg + 1'b1;
                result_given_next = (step.oc != hrhs_pkg::OC_GO_ON);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= hrhs_pkg::reset_state();
            pos_reg          <= '0;
            result_given_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            result_given_reg <= result_given_next;
        end
    end

    `HRHS_ASSERT_NEXT(a_result_marks_given, aclk, aresetn, res_valid && !last_w, result_given_reg)
    `HRHS_ASSERT_IMPLIES(a_single_result, aclk, aresetn, result_given_reg, !res_valid)
    `HRHS_ASSERT_NEXT(a_pos_advances, aclk, aresetn, take && !result_given_reg && !res_valid, pos_reg == POS_W'($past(pos_reg) + 1'b1))

endmodule

`default_nettype wire

### rtl/hrhs_out_stage.sv
// result register stage toward the downstream consumer
`default_nettype none

module hrhs_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           res_valid,
    input  wire hrhs_pkg::out_t res_data,
    output logic                res_room,
    output logic                m_valid,
    input  wire logic           m_ready,
    output hrhs_pkg::out_t      m_data
);

    logic           valid_reg;
    logic           valid_next;
    hrhs_pkg::out_t data_reg;

    assign res_room = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_room) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_room && res_valid) begin
            data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

### rtl/http_request_header_scanner_unit.sv
// top level of the http request header scanner
// Takes an HTTP request header one byte per transfer and gives one result per header
// (at the blank line, an error, a zero byte or the last byte; bytes after a result are
// dropped up to and including the next byte flagged end_of_packet). A byte can be
// taken every cycle: the scan state for one byte is updated from the input register,
// and the result lands in an output register, so m_valid rises when the result is
// registered there, after the byte that caused it has passed the input register and
// the scan logic. Throughput is one byte per cycle; only a full output register that
// is not being drained holds the input side. There is no clearing pass after reset.
`default_nettype none

module http_request_header_scanner_unit #(
    parameter int MAX_HEADER_BYTES = 4096
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire hrhs_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output hrhs_pkg::out_t      m_data
);

    logic           take;
    logic           byte_valid;
    hrhs_pkg::in_t  byte_data;
    logic           res_room;
    logic           res_valid;
    hrhs_pkg::out_t res_data;

    hrhs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    hrhs_scan_core #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_room   (res_room),
        .take       (take),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    hrhs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_room  (res_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking testbench for the http request header scanner: directed and random headers
`timescale 1ns / 1ps

module tb_top;

    localparam int HDR_MAX     = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 2000;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    hrhs_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    hrhs_pkg::out_t m_data;

    always #1 aclk = ~aclk;

    http_request_header_scanner_unit #(
        .MAX_HEADER_BYTES(HDR_MAX)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // scanner shadow state
    int unsigned hdr_pos;
    bit          on_fields;
    int          tok_no;
    bit          seg_empty;
    bit          cr_wait;
    int          mpos;
    bit [2:0]    mflags;
    bit          skip_lead;
    bit          name_set;
    bit          name_conn;
    logic [1:0]  ver_code;
    bit          get_seen;
    bit          conn_line_seen;
    bit          ka_state;
    int unsigned q_begin;
    int unsigned q_len;
    bit          q_seen;
    bit          draining;

    hrhs_pkg::out_t expected_results[$];
    logic [7:0]     pkt_bytes[$];

    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    bit hold_request = 1'b0;

    int mismatches        = 0;
    int bytes_sent        = 0;
    int bytes_scanned     = 0;
    int headers_sent      = 0;
    int results_predicted = 0;
    int results_checked   = 0;
    int input_stalls      = 0;
    int cycle_count       = 0;

    function automatic string word_for(bit t, int k);
        if (k == 2) begin
            return "Connection";
        end
        if (k == 0) begin
            if (t) return "close";
            return "GET";
        end
        if (t) return "keep-alive";
        return "HTTP/1.0";
    endfunction

    function automatic logic [7:0] lower_case(logic [7:0] c);
        return (c >= hrhs_pkg::CHAR_UP_A && c <= hrhs_pkg::CHAR_UP_Z)
               ? c + hrhs_pkg::CASE_DELTA : c;
    endfunction

    function automatic void seg_restart();
        seg_empty = 1'b1;
        mpos      = 0;
        mflags    = '1;
        skip_lead = 1'b1;
    endfunction

    function automatic void scan_reset();
        hdr_pos        = 0;
        on_fields      = 1'b0;
        tok_no         = 1;
        cr_wait        = 1'b0;
        seg_restart();
        name_set       = 1'b0;
        name_conn      = 1'b0;
        ver_code       = hrhs_pkg::VER_NONE;
        get_seen       = 1'b0;
        conn_line_seen = 1'b0;
        ka_state       = 1'b1;
        q_begin        = 0;
        q_len          = 0;
        q_seen         = 1'b0;
        draining       = 1'b0;
    endfunction

    // header values ignore case, the name and request line words do not
    function automatic bit hit_word(int k);
        string w;
        w = word_for(on_fields, k);
        if (!mflags[k]) begin
            return 1'b0;
        end
        if (!on_fields && k == 1) begin
            return mpos >= w.len();
        end
        return mpos == w.len();
    endfunction

    function automatic void take_char(logic [7:0] b);
        string      w;
        logic [7:0] c;
        seg_empty = 1'b0;
        if (on_fields && skip_lead && b == hrhs_pkg::CHAR_SPACE) begin
            mflags[2] = 1'b0;
            return;
        end
        skip_lead = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w = word_for(on_fields, k);
            if (mpos < w.len()) begin
                c = (on_fields && k != 2) ? lower_case(b) : b;
                if (c != w[mpos]) begin
                    mflags[k] = 1'b0;
                end
            end else if (!(!on_fields && k == 1)) begin
                mflags[k] = 1'b0;
            end
        end
        if (mpos < 15) begin
            mpos++;
        end
    endfunction

    function automatic hrhs_pkg::outcome_t plain_char(logic [7:0] b, int unsigned p);
        if (!on_fields && b == hrhs_pkg::CHAR_SPACE) begin
            if (!seg_empty) begin
                if (tok_no == 1) begin
                    if (!hit_word(0)) begin
                        return hrhs_pkg::OC_BAD_METHOD;
                    end
                    get_seen = 1'b1;
                end else if (tok_no == 2 && !q_seen) begin
                    q_seen = 1'b1;
                    q_len  = p - q_begin;
                end
                if (tok_no < 4) begin
                    tok_no++;
                end
            end
            if (!q_seen) begin
                q_begin = p + 1;
            end
            seg_restart();
            return hrhs_pkg::OC_GO_ON;
        end
        // a colon while the method is expected sets a header name, even on the request line
        if (b == hrhs_pkg::CHAR_COLON && tok_no == 1) begin
            name_set  = 1'b1;
            name_conn = hit_word(2);
            if (!on_fields && !q_seen) begin
                q_begin = p + 1;
            end
            tok_no = 0;
            seg_restart();
            return hrhs_pkg::OC_GO_ON;
        end
        take_char(b);
        return hrhs_pkg::OC_GO_ON;
    endfunction

    function automatic hrhs_pkg::outcome_t raw_char(logic [7:0] b, int unsigned p);
        if (b == hrhs_pkg::CHAR_CR) begin
            cr_wait = 1'b1;
            return hrhs_pkg::OC_GO_ON;
        end
        return plain_char(b, p);
    endfunction

    function automatic hrhs_pkg::outcome_t close_line();
        if (seg_empty && on_fields) begin
            return hrhs_pkg::OC_END_OK;
        end
        if (!on_fields) begin
            if (tok_no != 3) begin
                return hrhs_pkg::OC_BAD_LINE;
            end
            ver_code = hit_word(1) ? hrhs_pkg::VER_1_0 : hrhs_pkg::VER_NEWER;
        end else if (name_set && name_conn) begin
            if (hit_word(0)) begin
                ka_state = 1'b0;
            end else if (hit_word(1)) begin
                ka_state = 1'b1;
            end else begin
                ka_state = (ver_code == hrhs_pkg::VER_NEWER);
            end
            conn_line_seen = 1'b1;
        end
        on_fields = 1'b1;
        tok_no    = 1;
        seg_restart();
        return hrhs_pkg::OC_GO_ON;
    endfunction

    // advances the shadow scanner by one accepted byte; returns 1 with the header result
    function automatic bit scan_header_byte(input logic [7:0] b, input logic eop,
                                            output hrhs_pkg::out_t res);
        bit                 last;
        int unsigned        p;
        hrhs_pkg::outcome_t oc;
        res = '0;
        if (draining) begin
            if (eop) begin
                scan_reset();
            end
            return 1'b0;
        end
        bytes_scanned++;
        last = eop || hdr_pos >= HDR_MAX - 1;
        p    = hdr_pos;
        if (b == hrhs_pkg::CHAR_NUL) begin
            oc = hrhs_pkg::OC_END_OK;
        end else if (cr_wait) begin
            cr_wait = 1'b0;
            if (b == hrhs_pkg::CHAR_LF) begin
                oc = close_line();
            end else begin
                // lone cr is an ordinary byte
                oc = plain_char(hrhs_pkg::CHAR_CR, p);
                if (oc == hrhs_pkg::OC_GO_ON) begin
                    oc = raw_char(b, p);
                end
            end
        end else begin
            oc = raw_char(b, p);
        end
        hdr_pos++;
        if (oc == hrhs_pkg::OC_GO_ON && last) begin
            oc = hrhs_pkg::OC_END_OK;
        end
        if (oc == hrhs_pkg::OC_GO_ON) begin
            return 1'b0;
        end
        if (oc == hrhs_pkg::OC_END_OK) begin
            if (!conn_line_seen) begin
                ka_state = (ver_code == hrhs_pkg::VER_NEWER);
            end
            res.status       = hrhs_pkg::STATUS_OK;
            res.http_version = ver_code;
            res.keep_alive   = ka_state;
        end else begin
            res.status = (oc == hrhs_pkg::OC_BAD_METHOD) ? hrhs_pkg::STATUS_BAD_METHOD
                                                          : hrhs_pkg::STATUS_BAD_LINE;
        end
        res.method_is_get = get_seen;
        res.query_present = q_seen;
        if (q_seen) begin
            res.query_offset = q_begin[11:0];
            res.query_length = q_len[12:0];
        end
        if (last) begin
            scan_reset();
        end else begin
            draining = 1'b1;
        end
        results_predicted++;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        hrhs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no header result pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, m_data.status);
                check_field("method_is_get", want.method_is_get, m_data.method_is_get);
                check_field("http_version", want.http_version, m_data.http_version);
                check_field("keep_alive", want.keep_alive, m_data.keep_alive);
                check_field("query_present", want.query_present, m_data.query_present);
                check_field("query_offset", want.query_offset, m_data.query_offset);
                check_field("query_length", want.query_length, m_data.query_length);
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && s_valid && !s_ready) begin
            input_stalls++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[http_request_header_scanner_unit] ERROR");
            $finish;
        end
    end

    // result side ready, with random stalls and one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++) begin
                    @(posedge aclk);
                end
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        hrhs_pkg::in_t  item;
        hrhs_pkg::out_t res;
        int             gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.data_byte     = b;
        item.end_of_packet = eop;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
        if (scan_header_byte(b, eop, res)) begin
            expected_results.push_back(res);
        end
    endtask

    task automatic send_packet(input bit eop_last);
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(pkt_bytes[i], eop_last && i == n - 1);
        end
        pkt_bytes.delete();
        headers_sent++;
    endtask

    function automatic void add_byte(logic [7:0] b);
        pkt_bytes.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            pkt_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void add_line(string s);
        add_text(s);
        pkt_bytes.push_back(hrhs_pkg::CHAR_CR);
        pkt_bytes.push_back(hrhs_pkg::CHAR_LF);
    endfunction

    function automatic void add_rand_chars(int n, bit any_byte);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if (any_byte) begin
                c = 8'($urandom_range(1, 255));
            end else begin
                c = 8'($urandom_range(33, 126));
                if (c == hrhs_pkg::CHAR_COLON) begin
                    c = "_";
                end
            end
            pkt_bytes.push_back(c);
        end
    endfunction

    task automatic test_plain_requests();
        add_line("GET /index.html HTTP/1.1");
        add_line("Host: example");
        add_line("");
        send_packet(1'b1);
        add_line("GET /a?b=c HTTP/1.0");
        add_line("Accept: */*");
        add_line("");
        send_packet(1'b1);
    endtask

    task automatic test_connection_header();
        add_line("GET /c HTTP/1.1");
        add_line("Connection: close");
        add_line("");
        send_packet(1'b1);
        add_line("GET /k HTTP/1.0");
        add_line("Connection:   keep-alive");
        add_line("");
        send_packet(1'b1);
        add_line("GET /m HTTP/1.0");
        add_line("Connection: KEEP-Alive");
        add_line("");
        send_packet(1'b1);
        // unrecognised value falls back on the version
        add_line("GET /u HTTP/1.1");
        add_line("Connection: upgrade");
        add_line("");
        send_packet(1'b1);
        add_line("GET /w HTTP/1.1");
        add_line("Connection: close");
        add_line("Connection: keep-alive");
        add_line("");
        send_packet(1'b1);
        // header name compare is case sensitive
        add_line("GET /l HTTP/1.1");
        add_line("connection: close");
        add_line("");
        send_packet(1'b1);
    endtask

    task automatic test_request_line_forms();
        add_line("GET /t ");
        add_line("");
        send_packet(1'b1);
        add_line("POST /p HTTP/1.1");
        add_line("");
        send_packet(1'b1);
        add_line("GETX /p HTTP/1.1");
        add_line("");
        send_packet(1'b1);
        add_line("GET /two");
        add_line("");
        send_packet(1'b1);
        add_line("GET /a b HTTP/1.1");
        add_line("");
        send_packet(1'b1);
        add_line("  GET   /sp    HTTP/1.0.9");
        add_line("");
        send_packet(1'b1);
        add_line("");
        add_line("GET / HTTP/1.1");
        send_packet(1'b1);
    endtask

    task automatic test_line_quirks();
        add_line("GET /e HTTP/1.1");
        add_line("Host:");
        add_line("Connection: close");
        send_packet(1'b1);
        // continuation line reuses the previous name
        add_line("GET /r HTTP/1.1");
        add_line("Connection: keep-alive");
        add_line("close");
        add_line("");
        send_packet(1'b1);
        add_line("GET /n HTTP/1.0");
        add_line("keep-alive");
        add_line("");
        send_packet(1'b1);
        add_line("X:GET / HTTP/1.1");
        add_line("");
        send_packet(1'b1);
        add_text("GET /a");
        add_byte(hrhs_pkg::CHAR_CR);
        add_line("b HTTP/1.1");
        add_line("");
        send_packet(1'b1);
        add_text("GET / HTTP/1.1");
        add_byte(hrhs_pkg::CHAR_CR);
        add_byte(hrhs_pkg::CHAR_NUL);
        add_text("z");
        send_packet(1'b1);
    endtask

    task automatic test_early_termination();
        add_line("GET /q HTTP/1.1");
        add_text("Ho");
        add_byte(hrhs_pkg::CHAR_NUL);
        add_text("st: x");
        send_packet(1'b1);
        add_line("GET /abc HTTP/1.1");
        add_text("Host: a");
        send_packet(1'b1);
        // bytes after an error are dropped up to the end of packet
        add_line("POST / x");
        add_text("zzzz");
        send_packet(1'b1);
        add_text("GET /");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_line(" HTTP/1.1");
        add_text("X: ");
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_line("");
        add_line("");
        send_packet(1'b1);
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (12) begin
            add_byte(hrhs_pkg::CHAR_NUL);
            send_packet(1'b1);
        end
        add_line("GET /bp HTTP/1.1");
        add_line("");
        send_packet(1'b1);
    endtask

    function automatic void gen_well_formed();
        int n;
        if ($urandom_range(0, 15) == 0) begin
            add_byte(hrhs_pkg::CHAR_SPACE);
        end
        case ($urandom_range(0, 19))
            0:       add_text("POST");
            1:       add_text("get");
            2:       add_text("GETT");
            3:       add_text("GE");
            default: add_text("GET");
        endcase
        add_byte(hrhs_pkg::CHAR_SPACE);
        if ($urandom_range(0, 7) == 0) begin
            add_byte(hrhs_pkg::CHAR_SPACE);
        end
        if ($urandom_range(0, 9) != 0) begin
            add_byte("/");
        end
        add_rand_chars($urandom_range(0, 10), $urandom_range(0, 9) == 0);
        add_byte(hrhs_pkg::CHAR_SPACE);
        if ($urandom_range(0, 9) == 0) begin
            add_byte(hrhs_pkg::CHAR_SPACE);
        end
        case ($urandom_range(0, 9))
            0, 1, 2: add_text("HTTP/1.0");
            3:       add_text("HTTP/1.0.1");
            4:       add_text("HTTP/2");
            5:       add_text("http/1.0");
            6:       add_text("");
            default: add_text("HTTP/1.1");
        endcase
        add_line("");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                // line with no colon
                add_rand_chars($urandom_range(1, 8), 1'b0);
                add_line("");
                continue;
            end
            if ($urandom_range(0, 1) == 0) begin
                add_text("Connection");
                add_text(":");
                repeat ($urandom_range(0, 3)) add_byte(hrhs_pkg::CHAR_SPACE);
                case ($urandom_range(0, 7))
                    0:       add_text("close");
                    1:       add_text("keep-alive");
                    2:       add_text("Keep-Alive");
                    3:       add_text("CLOSE");
                    4:       add_text("closed");
                    5:       add_text("keep");
                    6:       add_text("upgrade");
                    default: add_rand_chars($urandom_range(1, 10), 1'b0);
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0:       add_text("Host");
                    1:       add_text("connection");
                    2:       add_text("Accept");
                    default: add_rand_chars($urandom_range(1, 8), 1'b0);
                endcase
                add_text(": ");
                add_rand_chars($urandom_range(1, 12), $urandom_range(0, 7) == 0);
            end
            add_line("");
        end
        case ($urandom_range(0, 19))
            0, 1:    add_byte(hrhs_pkg::CHAR_NUL);
            2, 3, 4: ;
            default: add_line("");
        endcase
        if ($urandom_range(0, 4) == 0) begin
            add_rand_chars($urandom_range(1, 5), 1'b1);
        end
    endfunction

    function automatic void corrupt_packet();
        int idx;
        idx = $urandom_range(0, pkt_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0: pkt_bytes[idx] = 8'($urandom_range(0, 255));
            1: if (pkt_bytes.size() > 1) pkt_bytes.delete(idx);
            2: pkt_bytes.insert(idx, hrhs_pkg::CHAR_CR);
            default: pkt_bytes.insert(idx, ($urandom_range(0, 1) == 0)
                                           ? hrhs_pkg::CHAR_SPACE : hrhs_pkg::CHAR_COLON);
        endcase
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 4))
                    0:       add_byte(hrhs_pkg::CHAR_CR);
                    1:       add_byte(hrhs_pkg::CHAR_LF);
                    2:       add_byte(hrhs_pkg::CHAR_SPACE);
                    3:       add_byte(hrhs_pkg::CHAR_COLON);
                    default: add_byte(hrhs_pkg::CHAR_NUL);
                endcase
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic test_random_traffic(input int byte_goal, input int result_goal);
        int first_bytes;
        int first_results;
        int kind;
        first_bytes   = bytes_scanned;
        first_results = results_predicted;
        while ((bytes_scanned - first_bytes) < byte_goal
               || (results_predicted - first_results) < result_goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                gen_well_formed();
            end else if (kind < 9) begin
                gen_well_formed();
                corrupt_packet();
            end else begin
                gen_noise();
            end
            send_packet(1'b1);
        end
    endtask

    initial begin
        int waited;
        scan_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_plain_requests();
        test_connection_header();
        test_request_line_forms();
        test_line_quirks();
        test_early_termination();
        test_output_backpressure();
        test_random_traffic(180, 5);
        // closing stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(60, 2);
        s_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d header results never arrived", expected_results.size());
            mismatches++;
        end
        repeat (8) @(posedge aclk);
        $display("covered %0d bytes (%0d scanned) in %0d headers, %0d results checked",
                 bytes_sent, bytes_scanned, headers_sent, results_checked);
        $display("input held off %0d cycles by result back-pressure, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("[http_request_header_scanner_unit] OK");
        end else begin
            $display("[http_request_header_scanner_unit] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hrhs_pkg.sv
rtl/hrhs_in_stage.sv
rtl/hrhs_scan_core.sv
rtl/hrhs_out_stage.sv
rtl/http_request_header_scanner_unit.sv
bench/tb_top.sv
